// File: sv/idea_cbc_pkg.sv
// Package for the IDEA CBC block encryptor: widths, register indexes,
// key schedule helpers and the modulo 65537 multiplier.
// No dependencies.
`timescale 1ns / 1ps

package idea_cbc_pkg;

  localparam int unsigned BlockW  = 64;
  localparam int unsigned WordW   = 16;
  localparam int unsigned KeyW    = 128;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 64;

  typedef logic [BlockW-1:0]  block_t;
  typedef logic [WordW-1:0]   word_t;
  typedef logic [KeyW-1:0]    key_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegKeyHigh = 2'd0;
  localparam cfg_idx_t RegKeyLow  = 2'd1;

  // round 8 is the output transform
  localparam logic [3:0] LastRound = 4'd8;

  // key rotation between groups of eight subkeys
  localparam logic [6:0] KeyRot = 7'd25;

  // Subkey at offset j from the current word pointer w. The register s holds
  // the key rotated so that the word at w sits in the top 16 bits.
  function automatic word_t key_word(key_t s, logic [2:0] w, logic [1:0] j);
    logic [2*KeyW-1:0] ss;
    logic [3:0]        pos;
    logic [6:0]        amt;
    ss  = {s, s};
    pos = {1'b0, w} + {2'b00, j};
    amt = {1'b0, j, 4'b0000} + (pos[3] ? KeyRot : 7'd0);
    return ss[8'd255 - {1'b0, amt} -: WordW];
  endfunction

  // Advance the schedule register by m words (m at most 3).
  function automatic key_t key_adv(key_t s, logic [2:0] w, logic [1:0] m);
    logic [2*KeyW-1:0] ss;
    logic [3:0]        pos;
    logic [6:0]        amt;
    ss  = {s, s};
    pos = {1'b0, w} + {2'b00, m};
    amt = {1'b0, m, 4'b0000} + (pos[3] ? KeyRot : 7'd0);
    return ss[8'd255 - {1'b0, amt} -: KeyW];
  endfunction

  // Multiplication modulo 65537, zero stands for 65536.
  function automatic word_t mul_mod(word_t a, word_t b);
    logic [2*WordW-1:0] p;
    word_t              lo;
    word_t              hi;
    word_t              r;
    p  = {16'd0, a} * {16'd0, b};
    lo = p[WordW-1:0];
    hi = p[2*WordW-1:WordW];
    if (a == '0) begin
      r = 16'd1 - b;
    end else if (b == '0) begin
      r = 16'd1 - a;
    end else begin
      r = lo - hi + {15'd0, (lo < hi)};
    end
    return r;
  endfunction

endpackage

// File: sv/idea_cbc_if.sv
// Handshake channel interfaces for the IDEA CBC encryptor: block input,
// result output and configuration write. Depends on idea_cbc_pkg.
`timescale 1ns / 1ps

interface idea_cbc_in_if import idea_cbc_pkg::*; ();
  logic   valid;
  logic   ready;
  block_t plain_block;
  logic   first_of_message;

  modport source (output valid, output plain_block, output first_of_message, input ready);
  modport sink   (input valid, input plain_block, input first_of_message, output ready);
endinterface

interface idea_cbc_out_if import idea_cbc_pkg::*; ();
  logic   valid;
  logic   ready;
  block_t cipher_block;

  modport source (output valid, output cipher_block, input ready);
  modport sink   (input valid, input cipher_block, output ready);
endinterface

interface idea_cbc_cfg_if import idea_cbc_pkg::*; ();
  logic                valid;
  logic                ready;
  cfg_idx_t            index;
  logic [CfgW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/idea_cbc_block_encryptor_top.sv
// IDEA CBC block encryptor: key registers, on-the-fly key schedule, one
// shared modulo 65537 multiplier under a round/phase sequencer.
// Depends on idea_cbc_pkg and the channel interfaces in idea_cbc_if.sv.
//
//   port    dir  transaction
//   blk_i   in   plain_block[63:0], first_of_message
//   res_o   out  cipher_block[63:0]
//   cfg_i   in   index[1:0] (0 key_high, 1 key_low), data[63:0]
//
// The result is registered after four multiplier passes per round over eight
// rounds, and two for the output transform. A new block is taken only in the
// idle state after the result is set, so blocks do not overlap.
// The single multiplier sets the block rate.
// blk_i.ready is high only while idle; the result sits in an output register.
// If the previous result is still held at the end, the last step waits.
// Reset clears keys and the chaining block; cfg_i is always ready.
`timescale 1ns / 1ps

module idea_cbc_block_encryptor_top import idea_cbc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  idea_cbc_in_if.sink            blk_i,
  idea_cbc_out_if.source         res_o,
  idea_cbc_cfg_if.sink           cfg_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  localparam logic [1:0] PhA = 2'd0;  // x0 * k0, the two adds
  localparam logic [1:0] PhD = 2'd1;  // x3 * k3
  localparam logic [1:0] PhE = 2'd2;  // (a ^ c) * k4
  localparam logic [1:0] PhF = 2'd3;  // (f + t0) * k5, round update

  logic       state_q;
  logic [1:0] phase_q;
  logic [3:0] round_q;
  logic [2:0] wp_q;
  block_t     keyhi_q, keylo_q;
  key_t       ks_q;
  block_t     x_q;
  word_t      a_q, b_q, c_q, d_q, t0_q;
  block_t     prev_q;
  block_t     out_q;
  logic       out_vld_q;

  word_t k0, k1, k2;
  word_t mul_a, mul_r, t2;
  logic  last_rnd, fin, stall, step, blk_acc, res_acc;

  assign k0 = key_word(ks_q, wp_q, 2'd0);
  assign k1 = key_word(ks_q, wp_q, 2'd1);
  assign k2 = key_word(ks_q, wp_q, 2'd2);

  always_comb begin
    case (phase_q)
      PhA:     mul_a = x_q[63:48];
      PhD:     mul_a = x_q[15:0];
      PhE:     mul_a = a_q ^ c_q;
      PhF:     mul_a = (b_q ^ d_q) + t0_q;
      default: mul_a = x_q[63:48];
    endcase
  end

  assign mul_r = mul_mod(mul_a, k0);
  assign t2    = t0_q + mul_r;

  assign last_rnd = (round_q == LastRound);
  assign fin      = (state_q == StRun) && last_rnd && (phase_q == PhD);
  assign stall    = fin && out_vld_q && !res_o.ready;
  assign step     = (state_q == StRun) && !stall;
  assign blk_acc  = blk_i.valid && blk_i.ready;
  assign res_acc  = res_o.valid && res_o.ready;

  assign blk_i.ready      = (state_q == StIdle);
  assign res_o.valid      = out_vld_q;
  assign res_o.cipher_block = out_q;
  assign cfg_i.ready      = 1'b1;

  // control, keys and chaining block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      phase_q   <= PhA;
      round_q   <= '0;
      wp_q      <= '0;
      out_vld_q <= 1'b0;
      keyhi_q   <= '0;
      keylo_q   <= '0;
      prev_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          RegKeyHigh: keyhi_q <= cfg_i.data;
          RegKeyLow:  keylo_q <= cfg_i.data;
          default:    ;
        endcase
      end
      if (res_acc) begin
        out_vld_q <= 1'b0;
      end
      if (blk_acc) begin
        state_q <= StRun;
        phase_q <= PhA;
        round_q <= '0;
        wp_q    <= '0;
      end else if (step) begin
        case (phase_q)
          PhA: begin
            phase_q <= PhD;
            wp_q    <= wp_q + 3'd3;
          end
          PhD: begin
            wp_q <= wp_q + 3'd1;
            if (last_rnd) begin
              state_q   <= StIdle;
              out_vld_q <= 1'b1;
              prev_q    <= {a_q, b_q, c_q, mul_r};
            end else begin
              phase_q <= PhE;
            end
          end
          PhE: begin
            phase_q <= PhF;
            wp_q    <= wp_q + 3'd1;
          end
          PhF: begin
            phase_q <= PhA;
            wp_q    <= wp_q + 3'd1;
            round_q <= round_q + 4'd1;
          end
          default: phase_q <= PhA;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (blk_acc) begin
      x_q  <= blk_i.first_of_message ? blk_i.plain_block
                                     : (blk_i.plain_block ^ prev_q);
      ks_q <= {keyhi_q, keylo_q};
    end else if (step) begin
      case (phase_q)
        PhA: begin
          a_q  <= mul_r;
          ks_q <= key_adv(ks_q, wp_q, 2'd3);
          if (last_rnd) begin
            b_q <= x_q[31:16] + k1;
            c_q <= x_q[47:32] + k2;
          end else begin
            b_q <= x_q[47:32] + k1;
            c_q <= x_q[31:16] + k2;
          end
        end
        PhD: begin
          d_q  <= mul_r;
          ks_q <= key_adv(ks_q, wp_q, 2'd1);
          if (last_rnd) begin
            out_q <= {a_q, b_q, c_q, mul_r};
          end
        end
        PhE: begin
          t0_q <= mul_r;
          ks_q <= key_adv(ks_q, wp_q, 2'd1);
        end
        PhF: begin
          x_q  <= {a_q ^ mul_r, c_q ^ mul_r, b_q ^ t2, d_q ^ t2};
          ks_q <= key_adv(ks_q, wp_q, 2'd1);
        end
        default: ;
      endcase
    end
  end

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_acc |=> (state_q == StRun && round_q == '0 && phase_q == PhA && wp_q == '0))
    else $error("sequencer not restarted on block acceptance");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    round_q <= LastRound)
    else $error("round counter past output transform");

  a_out_phases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && last_rnd) |-> (phase_q == PhA || phase_q == PhD))
    else $error("output transform entered a round-only phase");

  a_key_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && last_rnd && phase_q == PhA) |-> (wp_q == '0))
    else $error("subkey pointer misaligned at output transform");

  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && !stall) |=> (res_o.valid && prev_q == out_q && blk_i.ready))
    else $error("result and chaining block disagree");

endmodule

// File: tb/sv/idea_cbc_tb_pkg.sv
// Cipher tracker for the IDEA CBC encryptor bench: key schedule, IDEA
// encryption and CBC chaining, plus the queue of expected ciphertexts.
// Depends on idea_cbc_pkg.
`timescale 1ns / 1ps

package idea_cbc_tb_pkg;
  import idea_cbc_pkg::*;

  // indexes with no register behind them, writes are dropped
  localparam cfg_idx_t RegSpare2 = 2'd2;
  localparam cfg_idx_t RegSpare3 = 2'd3;

  localparam int SubkeyCount   = 52;
  localparam int MismatchShown = 10;

  class cbc_cipher_book;
    key_t   key;
    word_t  subkey[SubkeyCount];
    block_t chain;
    block_t cipher_due[$];
    int     mismatches;

    function new();
      key        = '0;
      chain      = '0;
      mismatches = 0;
      expand_key();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CfgW-1:0] d);
      if (idx == RegKeyHigh) begin
        key[KeyW-1:CfgW] = d;
      end else if (idx == RegKeyLow) begin
        key[CfgW-1:0] = d;
      end else begin
        return;
      end
      expand_key();
    endfunction

    // 128-bit key cut into words, rotated left by 25 after every eight
    function void expand_key();
      key_t k;
      k = key;
      for (int n = 0; n < SubkeyCount; n++) begin
        subkey[n] = k[KeyW-1-WordW*(n%8) -: WordW];
        if (n % 8 == 7) k = {k[KeyW-26:0], k[KeyW-1:KeyW-25]};
      end
    endfunction

    function word_t mul65537(word_t a, word_t b);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] p;
      x = (a == '0) ? 64'd65536 : {48'd0, a};
      y = (b == '0) ? 64'd65536 : {48'd0, b};
      p = (x * y) % 64'd65537;
      return p[WordW-1:0];
    endfunction

    function block_t encrypt(block_t blk);
      word_t x0, x1, x2, x3;
      word_t a, b, c, d, e, f, t0, t1, t2;
      int    base;
      x0 = blk[63:48];
      x1 = blk[47:32];
      x2 = blk[31:16];
      x3 = blk[15:0];
      for (int r = 0; r < 8; r++) begin
        base = 6 * r;
        a  = mul65537(x0, subkey[base]);
        b  = x1 + subkey[base+1];
        c  = x2 + subkey[base+2];
        d  = mul65537(x3, subkey[base+3]);
        e  = a ^ c;
        f  = b ^ d;
        t0 = mul65537(e, subkey[base+4]);
        t1 = mul65537(f + t0, subkey[base+5]);
        t2 = t0 + t1;
        x0 = a ^ t1;
        x1 = c ^ t1;
        x2 = b ^ t2;
        x3 = d ^ t2;
      end
      return {mul65537(x0, subkey[48]), word_t'(x2 + subkey[49]),
              word_t'(x1 + subkey[50]), mul65537(x3, subkey[51])};
    endfunction

    function void take_plain(block_t plain, logic first);
      block_t blk;
      blk = first ? plain : (plain ^ chain);
      chain = encrypt(blk);
      cipher_due.push_back(chain);
    endfunction

    function void check_cipher(block_t got);
      block_t want;
      if (cipher_due.size() == 0) begin
        if (mismatches < MismatchShown)
          $display("[%0t] unexpected cipher transaction: got %h", $realtime, got);
        mismatches++;
        return;
      end
      want = cipher_due.pop_front();
      if (got !== want) begin
        if (mismatches < MismatchShown)
          $display("[%0t] cipher_block mismatch: expected %h actual %h",
                   $realtime, want, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return cipher_due.size();
    endfunction
  endclass

endpackage

// File: tb/sv/tb_top.sv
// Top-level bench for idea_cbc_block_encryptor_top: drives keys and plaintext
// blocks with random idling, checks every ciphertext against the tracker.
// Depends on idea_cbc_pkg, idea_cbc_if.sv and idea_cbc_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
  import idea_cbc_pkg::*;
  import idea_cbc_tb_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandPhases  = 8;
  localparam int PhaseBlocks = 112;
  localparam int DrainCycles = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  bit   feed_idle  = 1'b1;
  bit   drain_idle = 1'b1;

  cbc_cipher_book book;

  idea_cbc_in_if  blk_if ();
  idea_cbc_out_if res_if ();
  idea_cbc_cfg_if cfg_if ();

  idea_cbc_block_encryptor_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .blk_i  (blk_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic block_t rand_block();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t corner_word();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {corner_word(), corner_word(), corner_word(), corner_word()};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // leaves valid high, caller lowers it after the last write
  task automatic cfg_put(cfg_idx_t idx, logic [CfgW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    book.write_reg(idx, d);
  endtask

  task automatic send_block(block_t b, logic first);
    int gap;
    gap = feed_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      blk_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    blk_if.valid            <= 1'b1;
    blk_if.plain_block      <= b;
    blk_if.first_of_message <= first;
    do @(posedge clk_i); while (!blk_if.ready);
    book.take_plain(b, first);
  endtask

  task automatic settle();
    blk_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  // result side
  initial begin
    int gap;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = drain_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      book.check_cipher(res_if.cipher_block);
    end
  end

  initial begin
    int  sent;
    int  len;
    bit  first;
    book = new();
    blk_if.valid            <= 1'b0;
    blk_if.plain_block      <= '0;
    blk_if.first_of_message <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= RegKeyHigh;
    cfg_if.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero key; chained block right after reset sees a zero chain
    send_block(64'h0000_0000_0000_0000, 1'b0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_block(64'h0000_FFFF_0000_FFFF, 1'b0);
    settle();

    cfg_put(RegKeyHigh, '1);
    cfg_put(RegKeyLow, '1);
    cfg_put(RegSpare2, {$urandom, $urandom});
    cfg_put(RegSpare3, '1);
    cfg_if.valid <= 1'b0;
    send_block(64'h0000_0000_0000_0000, 1'b1);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_block(64'h0001_0001_0001_0001, 1'b0);
    send_block(64'h8000_7FFF_8000_7FFF, 1'b0);
    settle();

    // key change inside a message, chain carries over
    cfg_put(RegKeyHigh, 64'h0001_0002_0003_0004);
    cfg_put(RegKeyLow, 64'h0005_0006_0007_0008);
    cfg_if.valid <= 1'b0;
    send_block(64'h1234_5678_9ABC_DEF0, 1'b0);
    send_block(64'hFFFF_0000_FFFF_0000, 1'b0);
    send_block(64'h0000_0001_0002_0003, 1'b1);
    send_block(64'h0000_0000_0000_0000, 1'b0);
    settle();

    for (int ph = 0; ph < RandPhases; ph++) begin
      feed_idle  = ($urandom_range(0, 3) != 0);
      drain_idle = ($urandom_range(0, 3) != 0);
      if (ph == 0 || $urandom_range(0, 3) != 0) cfg_put(RegKeyHigh, pick_key());
      if (ph == 0 || $urandom_range(0, 3) != 0) cfg_put(RegKeyLow, pick_key());
      if ($urandom_range(0, 3) == 0) cfg_put(RegSpare2, {$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) cfg_put(RegSpare3, {$urandom, $urandom});
      cfg_if.valid <= 1'b0;
      sent = 0;
      while (sent < PhaseBlocks) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          first = (i == 0);
          if ($urandom_range(0, 9) == 0) first = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 15) == 0)
            send_block({corner_word(), corner_word(), corner_word(), corner_word()}, first);
          else
            send_block(rand_block(), first);
          sent++;
        end
      end
      settle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
